[rtl/ilic_pkg.sv]
`timescale 1ns / 1ps

package ilic_pkg;

    localparam int DEFAULT_LIST_DEPTH = 1024;
    localparam int DEFAULT_NODE_BITS  = 30;

    localparam int ID_W    = 30;
    localparam int COUNT_W = 31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h4000_0000;

    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_COUNT    = 2'd2;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] node_id;
        logic            is_left_end;
        logic            is_right_end;
    } ilic_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] common_count;
        logic               overflow;
    } ilic_result_t;

endpackage

[rtl/interval_list_intersection_count.sv]
`timescale 1ns / 1ps
// append transaction: no result
// count transaction: each merge step is a registered list read, then a compare in the
//   shared merge unit; at most length_a + length_b steps, then a done state before idle
// a new transaction is taken only once the block is back in idle
// reset clears the list lengths, the overflow flag, the sequencer and the output valid;
//   list memories are not cleared

module interval_list_intersection_count
    import ilic_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int NODE_BITS  = DEFAULT_NODE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  ilic_item_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output ilic_result_t result
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam int PW = $clog2(LIST_DEPTH + 2);
    localparam int WW = NODE_BITS + 2;
    localparam int AD = NODE_BITS + 1;
    localparam int SW = ((AD > COUNT_W) ? AD : COUNT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [WW-1:0] mem_a [LIST_DEPTH];
    logic [WW-1:0] mem_b [LIST_DEPTH];

    logic [LW-1:0] len_a_reg, len_a_next;
    logic [LW-1:0] len_b_reg, len_b_next;
    logic          overflowed_reg, overflowed_next;
    logic [PW-1:0] pa_reg, pa_next;
    logic [PW-1:0] pb_reg, pb_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AD-1:0] add_reg, add_next;
    logic          result_valid_reg, result_valid_next;
    ilic_result_t  result_reg, result_next;

    logic [WW-1:0] a0_reg, a1_reg, b0_reg, b1_reg;

    logic                  accept;
    logic [NODE_BITS+ID_W-1:0] node_ext;
    logic [WW-1:0]         word_in;
    logic                  wr_a, wr_b;
    logic [PW-1:0]         pa_inc, pb_inc;
    logic                  walk_on, load_out;
    logic [SW-1:0]         sum;

    logic [NODE_BITS-1:0] na, nb, ra, rb, hi, lo;
    logic                 a_right, a_left, b_right, b_left;
    logic [1:0]           step_a, step_b;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign node_ext = {{NODE_BITS{1'b0}}, item.node_id};
    assign word_in  = {item.is_right_end, item.is_left_end, node_ext[NODE_BITS-1:0]};

    assign wr_a = accept && (item.op == OP_APPEND_A) && (len_a_reg < LW'(LIST_DEPTH));
    assign wr_b = accept && (item.op == OP_APPEND_B) && (len_b_reg < LW'(LIST_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[len_a_reg[AW-1:0]] <= word_in;
        end
        if (wr_b)
        begin
            mem_b[len_b_reg[AW-1:0]] <= word_in;
        end
    end

    // read the word under each pointer and its successor
    assign pa_inc = pa_reg + PW'(1);
    assign pb_inc = pb_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        a0_reg <= mem_a[pa_reg[AW-1:0]];
        a1_reg <= mem_a[pa_inc[AW-1:0]];
        b0_reg <= mem_b[pb_reg[AW-1:0]];
        b1_reg <= mem_b[pb_inc[AW-1:0]];
    end

    // merge unit
    always_comb
    begin
        na      = a0_reg[NODE_BITS-1:0];
        nb      = b0_reg[NODE_BITS-1:0];
        a_left  = a0_reg[NODE_BITS];
        b_left  = b0_reg[NODE_BITS];
        a_right = a0_reg[NODE_BITS+1];
        b_right = b0_reg[NODE_BITS+1];
        // a left end that is the last word closes on itself
        ra      = (pa_inc < PW'(len_a_reg)) ? a1_reg[NODE_BITS-1:0] : na;
        rb      = (pb_inc < PW'(len_b_reg)) ? b1_reg[NODE_BITS-1:0] : nb;
        hi      = (ra < rb) ? ra : rb;
        lo      = (na > nb) ? na : nb;
        step_a  = 2'd0;
        step_b  = 2'd0;
        add_next = '0;
        if (a_right)
        begin
            step_a = 2'd1;
        end
        else if (b_right)
        begin
            step_b = 2'd1;
        end
        else if (a_left && b_left)
        begin
            if (ra < nb)
            begin
                step_a = 2'd2;
            end
            else if (na > rb)
            begin
                step_b = 2'd2;
            end
            else
            begin
                if (hi >= lo)
                begin
                    add_next = AD'(hi - lo) + AD'(1);
                end
                if (ra <= rb)
                begin
                    step_a = 2'd2;
                end
                if (ra >= rb)
                begin
                    step_b = 2'd2;
                end
            end
        end
        else if (a_left)
        begin
            if (nb < na)
            begin
                step_b = 2'd1;
            end
            else if (nb > ra)
            begin
                step_a = 2'd1;
            end
            else
            begin
                add_next = AD'(1);
                step_b   = 2'd1;
            end
        end
        else if (b_left)
        begin
            if (na < nb)
            begin
                step_a = 2'd1;
            end
            else if (na > rb)
            begin
                step_b = 2'd2;
            end
            else
            begin
                add_next = AD'(1);
                step_a   = 2'd1;
            end
        end
        else
        begin
            if (na <= nb)
            begin
                step_a = 2'd1;
            end
            if (nb <= na)
            begin
                step_b = 2'd1;
            end
            if (na == nb)
            begin
                add_next = AD'(1);
            end
        end
    end

    // saturating accumulate of the previous step's contribution
    assign sum = SW'(count_reg) + SW'(add_reg);

    assign walk_on  = (pa_reg < PW'(len_a_reg)) && (pb_reg < PW'(len_b_reg));
    assign load_out = (state_reg == S_DONE) && (!result_valid_reg || result_ready);

    always_comb
    begin
        state_next        = state_reg;
        len_a_next        = len_a_reg;
        len_b_next        = len_b_reg;
        overflowed_next   = overflowed_reg;
        pa_next           = pa_reg;
        pb_next           = pb_reg;
        count_next        = count_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.op)
                        OP_APPEND_A:
                        begin
                            if (wr_a)
                            begin
                                len_a_next = len_a_reg + LW'(1);
                            end
                            else
                            begin
                                overflowed_next = 1'b1;
                            end
                        end
                        OP_APPEND_B:
                        begin
                            if (wr_b)
                            begin
                                len_b_next = len_b_reg + LW'(1);
                            end
                            else
                            begin
                                overflowed_next = 1'b1;
                            end
                        end
                        OP_COUNT:
                        begin
                            pa_next    = '0;
                            pb_next    = '0;
                            count_next = '0;
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                count_next = (sum >= SW'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
                state_next = walk_on ? S_EVAL : S_DONE;
            end
            S_EVAL:
            begin
                pa_next    = pa_reg + PW'(step_a);
                pb_next    = pb_reg + PW'(step_b);
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    result_next.common_count = count_reg;
                    result_next.overflow     = overflowed_reg;
                    result_valid_next        = 1'b1;
                    len_a_next               = '0;
                    len_b_next               = '0;
                    overflowed_next          = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            len_a_reg        <= '0;
            len_b_reg        <= '0;
            overflowed_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            add_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            len_a_reg        <= len_a_next;
            len_b_reg        <= len_b_next;
            overflowed_reg   <= overflowed_next;
            result_valid_reg <= result_valid_next;
            // contribution of the step is folded in during the next read cycle
            if (state_reg == S_EVAL)
            begin
                add_reg <= add_next;
            end
            else if (state_reg != S_DONE)
            begin
                add_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.common_count <= COUNT_MAX))
        else $error("count above saturation limit");

    a_clear_after_count: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (len_a_reg == '0) && (len_b_reg == '0) && !overflowed_reg
                     && result_valid_reg)
        else $error("lists not emptied after count");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (pa_reg < PW'(len_a_reg)) && (pb_reg < PW'(len_b_reg)))
        else $error("merge step beyond list end");

endmodule

[tb/sv/tb_interval_list_intersection_count.sv]
`timescale 1ns / 1ps

import ilic_pkg::*;

class count_scoreboard;
    ilic_item_t   words_a [DEFAULT_LIST_DEPTH];
    ilic_item_t   words_b [DEFAULT_LIST_DEPTH];
    int unsigned  len_a;
    int unsigned  len_b;
    bit           dropped;
    ilic_result_t count_q[$];
    int unsigned  mismatches;
    int unsigned  counts_checked;
    int unsigned  overflow_counts;

    function new();
        len_a           = 0;
        len_b           = 0;
        dropped         = 1'b0;
        mismatches      = 0;
        counts_checked  = 0;
        overflow_counts = 0;
    endfunction

    function int unsigned pending();
        return count_q.size();
    endfunction

    // interval end comes from the next word, or the left end itself when last in list
    function longint unsigned end_node(bit in_b, int unsigned p);
        if (in_b)
            return (p + 1 < len_b) ? words_b[p + 1].node_id : words_b[p].node_id;
        return (p + 1 < len_a) ? words_a[p + 1].node_id : words_a[p].node_id;
    endfunction

    function longint unsigned common_nodes();
        int unsigned     pa;
        int unsigned     pb;
        longint unsigned acc;
        longint unsigned add;
        longint unsigned na;
        longint unsigned nb;
        longint unsigned ra;
        longint unsigned rb;
        longint unsigned hi;
        longint unsigned lo;
        ilic_item_t      wa;
        ilic_item_t      wb;
        pa  = 0;
        pb  = 0;
        acc = 0;
        while (pa < len_a && pb < len_b)
        begin
            wa  = words_a[pa];
            wb  = words_b[pb];
            na  = wa.node_id;
            nb  = wb.node_id;
            add = 0;
            if (wa.is_right_end)
                pa++;
            else if (wb.is_right_end)
                pb++;
            else if (wa.is_left_end && wb.is_left_end)
            begin
                ra = end_node(1'b0, pa);
                rb = end_node(1'b1, pb);
                if (ra < nb)
                    pa += 2;
                else if (na > rb)
                    pb += 2;
                else
                begin
                    hi = (ra < rb) ? ra : rb;
                    lo = (na > nb) ? na : nb;
                    if (hi >= lo)
                        add = hi - lo + 1;
                    if (ra < rb)
                        pa += 2;
                    else if (ra > rb)
                        pb += 2;
                    else
                    begin
                        pa += 2;
                        pb += 2;
                    end
                end
            end
            else if (wa.is_left_end)
            begin
                ra = end_node(1'b0, pa);
                if (nb < na)
                    pb++;
                else if (nb > ra)
                    pa++;
                else
                begin
                    add = 1;
                    pb++;
                end
            end
            else if (wb.is_left_end)
            begin
                rb = end_node(1'b1, pb);
                if (na < nb)
                    pa++;
                else if (na > rb)
                    pb += 2;
                else
                begin
                    add = 1;
                    pa++;
                end
            end
            else
            begin
                if (na < nb)
                    pa++;
                else if (nb < na)
                    pb++;
                else
                begin
                    add = 1;
                    pa++;
                    pb++;
                end
            end
            acc += add;
            if (acc > COUNT_MAX)
                acc = COUNT_MAX;
        end
        return acc;
    endfunction

    function void note_item(ilic_item_t it);
        ilic_result_t want;
        case (it.op)
            OP_APPEND_A:
            begin
                if (len_a < DEFAULT_LIST_DEPTH)
                begin
                    words_a[len_a] = it;
                    len_a++;
                end
                else
                    dropped = 1'b1;
            end
            OP_APPEND_B:
            begin
                if (len_b < DEFAULT_LIST_DEPTH)
                begin
                    words_b[len_b] = it;
                    len_b++;
                end
                else
                    dropped = 1'b1;
            end
            OP_COUNT:
            begin
                want.common_count = COUNT_W'(common_nodes());
                want.overflow     = dropped;
                count_q.insert(count_q.size(), want);
                len_a   = 0;
                len_b   = 0;
                dropped = 1'b0;
            end
            default:
                ;
        endcase
    endfunction

    function void check_result(ilic_result_t got);
        ilic_result_t want;
        if (count_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: count %0d overflow %0b",
                         got.common_count, got.overflow);
            return;
        end
        want = count_q.pop_front();
        counts_checked++;
        if (want.overflow)
            overflow_counts++;
        if (got.common_count !== want.common_count || got.overflow !== want.overflow)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("count %0d: expected count %0d overflow %0b, got count %0d overflow %0b",
                         counts_checked, want.common_count, want.overflow,
                         got.common_count, got.overflow);
        end
    endfunction
endclass

module tb_interval_list_intersection_count;
    import ilic_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned MAX_ID       = 32'h3FFF_FFFF;
    localparam int unsigned TOTAL_ITEMS  = 1900;
    localparam int          LONG_HOLD    = 400;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    ilic_item_t   item;
    logic         result_valid;
    logic         result_ready;
    ilic_result_t result;

    count_scoreboard sb;
    ilic_item_t      stim_q[$];
    ilic_item_t      set_a_q[$];
    ilic_item_t      set_b_q[$];
    bit              idle_on;
    bit              long_hold_req;
    int              stall_left;
    int unsigned     accepted_items;
    int unsigned     ignored_items;
    int unsigned     set_no;
    int              na;
    int              nb;

    always #5 clk = ~clk;

    interval_list_intersection_count u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    function automatic ilic_item_t make_word(logic [1:0] op, longint unsigned id, bit l, bit r);
        ilic_item_t w;
        w.op           = op;
        w.node_id      = ID_W'((id > MAX_ID) ? MAX_ID : id);
        w.is_left_end  = l;
        w.is_right_end = r;
        return w;
    endfunction

    function automatic void add(logic [1:0] op, longint unsigned id, bit l, bit r);
        stim_q.insert(stim_q.size(), make_word(op, id, l, r));
    endfunction

    function automatic void put_word(bit to_b, longint unsigned id, bit l, bit r);
        if (to_b)
            set_b_q.insert(set_b_q.size(), make_word(OP_APPEND_B, id, l, r));
        else
            set_a_q.insert(set_a_q.size(), make_word(OP_APPEND_A, id, l, r));
    endfunction

    // mostly sorted singles and intervals, with stray and reversed words when noisy
    function automatic void gen_list(bit to_b, int n, longint unsigned base, bit noisy, bit wide);
        longint unsigned cur;
        longint unsigned span;
        int              k;
        int              pick;
        cur = base;
        k   = 0;
        while (k < n)
        begin
            pick = $urandom_range(0, 9);
            if (noisy && pick == 0)
            begin
                put_word(to_b, $urandom_range(0, 1) ? longint'($urandom_range(0, MAX_ID))
                                                    : cur + $urandom_range(0, 6),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                k++;
            end
            else if (noisy && pick == 1 && k + 2 <= n)
            begin
                span = $urandom_range(1, 5);
                put_word(to_b, cur + span, 1'b1, 1'b0);
                put_word(to_b, cur, 1'b0, 1'b1);
                cur += span + $urandom_range(1, 3);
                k   += 2;
            end
            else if (pick < 6)
            begin
                span = wide ? $urandom_range(0, 1 << 20) : $urandom_range(0, 8);
                put_word(to_b, cur, 1'b1, 1'b0);
                k++;
                // a left end may be the last word of the list
                if (k < n)
                begin
                    put_word(to_b, cur + span, 1'b0, 1'b1);
                    k++;
                end
                cur += span + $urandom_range(1, 3);
            end
            else
            begin
                put_word(to_b, cur, 1'b0, 1'b0);
                cur += $urandom_range(1, 3);
                k++;
            end
        end
    endfunction

    function automatic void build_set(int len_a, int len_b, bit noisy, bit wide, bit shared);
        longint unsigned base_a;
        longint unsigned base_b;
        int unsigned     top;
        top    = wide ? MAX_ID - 40_000_000 : MAX_ID - 100_000;
        base_a = $urandom_range(0, top);
        base_b = shared ? base_a + $urandom_range(0, 20) : longint'($urandom_range(0, top));
        set_a_q.delete();
        set_b_q.delete();
        gen_list(1'b0, len_a, base_a, noisy, wide);
        gen_list(1'b1, len_b, base_b, noisy, wide);
        while (set_a_q.size() + set_b_q.size() > 0)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                add(OP_UNUSED, $urandom_range(0, MAX_ID), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
            if (set_b_q.size() == 0 || (set_a_q.size() != 0 && $urandom_range(0, 1)))
                stim_q.insert(stim_q.size(), set_a_q.pop_front());
            else
                stim_q.insert(stim_q.size(), set_b_q.pop_front());
        end
        add(OP_COUNT, $urandom_range(0, MAX_ID), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
    endfunction

    // valid is left high at the end so that the next set follows back to back
    task automatic send_all();
        ilic_item_t it;
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            item_valid <= 1'b1;
            item       <= it;
            do
                @(posedge clk);
            while (!item_ready);
            sb.note_item(it);
            if (it.op == OP_UNUSED)
                ignored_items++;
            else
                accepted_items++;
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        stall_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_result(result);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left   = $urandom_range(1, 13) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        idle_on        = 1'b1;
        long_hold_req  = 1'b0;
        accepted_items = 0;
        ignored_items  = 0;
        set_no         = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty lists, then the unused op
        add(OP_COUNT, MAX_ID, 1'b1, 1'b1);
        add(OP_UNUSED, MAX_ID, 1'b1, 1'b1);
        // singles at both id extremes, overlapping intervals, a word with both flags
        add(OP_APPEND_A, 0, 1'b0, 1'b0);
        add(OP_APPEND_A, 5, 1'b0, 1'b0);
        add(OP_APPEND_A, 10, 1'b1, 1'b0);
        add(OP_APPEND_A, 20, 1'b0, 1'b1);
        add(OP_APPEND_A, MAX_ID, 1'b0, 1'b0);
        add(OP_APPEND_B, 5, 1'b0, 1'b0);
        add(OP_APPEND_B, 15, 1'b1, 1'b0);
        add(OP_APPEND_B, 30, 1'b0, 1'b1);
        add(OP_APPEND_B, 40, 1'b1, 1'b1);
        add(OP_APPEND_B, MAX_ID, 1'b0, 1'b0);
        add(OP_COUNT, 0, 1'b0, 1'b0);
        // full-range intervals drive the count into saturation
        repeat (2)
        begin
            add(OP_APPEND_A, 0, 1'b1, 1'b0);
            add(OP_APPEND_A, MAX_ID, 1'b0, 1'b1);
            add(OP_APPEND_B, 0, 1'b1, 1'b0);
            add(OP_APPEND_B, MAX_ID, 1'b0, 1'b1);
        end
        add(OP_COUNT, MAX_ID, 1'b0, 1'b1);
        // reversed interval with empty overlap, left end closing list a
        add(OP_APPEND_A, 50, 1'b1, 1'b0);
        add(OP_APPEND_A, 40, 1'b0, 1'b1);
        add(OP_APPEND_A, 70, 1'b1, 1'b0);
        add(OP_APPEND_B, 30, 1'b1, 1'b0);
        add(OP_APPEND_B, 60, 1'b0, 1'b1);
        add(OP_APPEND_B, 70, 1'b0, 1'b0);
        add(OP_COUNT, 1, 1'b1, 1'b0);
        send_all();
        drain_results();

        // list a past its depth
        build_set(DEFAULT_LIST_DEPTH + 2, 24, 1'b0, 1'b0, 1'b1);
        send_all();
        drain_results();

        while (accepted_items < TOTAL_ITEMS)
        begin
            if (accepted_items > TOTAL_ITEMS * 85 / 100)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            if (set_no == 4)
            begin
                // receiver stalls while the sender keeps offering
                idle_on       = 1'b0;
                long_hold_req = 1'b1;
            end
            if (set_no == 10)
                drain_results();
            na = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
            nb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
            build_set(na, nb, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0,
                      $urandom_range(0, 4) != 0);
            send_all();
            set_no++;
        end
        drain_results();
        repeat (100) @(posedge clk);

        $display("checked %0d counts (%0d with dropped words) over %0d list/count transactions",
                 sb.counts_checked, sb.overflow_counts, accepted_items);
        $display("%0d unused-op transactions, %0d mismatches", ignored_items, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
        begin
            if (sb.pending() != 0)
                $display("%0d counts never arrived", sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d counts outstanding", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
rtl/ilic_pkg.sv
rtl/interval_list_intersection_count.sv
tb/sv/tb_interval_list_intersection_count.sv
